FILE: src/mgsfr_pkg.sv
package mgsfr_pkg;

  // Frame geometry of the read response.
  localparam int unsigned FrameLen = 21;
  localparam int unsigned CntW     = 5;

  // Header bytes that open a valid response.
  localparam logic [7:0] MaxAddr   = 8'h04;
  localparam logic [7:0] FuncRead  = 8'h04;
  localparam logic [7:0] ByteCount = 8'h10;

  // Modbus CRC-16 seed and reflected polynomial.
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;

  // Reset value of the idle limit register.
  localparam logic [15:0] IdleLimitRst = 16'd100;

  // Input beat: a received byte or an idle tick.
  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_item_t;

  // Result beat: one per completed frame.
  typedef struct packed {
    logic [1:0]  sensor_index;
    logic        crc_ok;
    logic        address_ok;
    logic        accepted;
    logic [15:0] pattern_word;
    logic        pattern_known;
    logic [1:0]  strip_count;
    logic [15:0] left_ofs;
    logic [15:0] mid_ofs;
    logic [15:0] right_ofs;
  } out_item_t;

endpackage

FILE: src/modbus_guide_sensor_frame_receiver_core.sv
// Modbus RTU guide-sensor response receiver with bytewise CRC-16 check.
// Throughput: one input beat per cycle while in_ready_o is high; the bytewise
// CRC update and the frame decode both sit between the state registers and the
// result register. A result held there sends a new frame's result to the skid.
// in_ready_o drops only while both the result register and the skid register
// hold results. Reset is asynchronous, active low, and restarts the hunt.
module modbus_guide_sensor_frame_receiver_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mgsfr_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mgsfr_pkg::out_item_t out_data_o,
  input  logic                 cfg_we_i,
  input  logic [15:0]          cfg_wdata_i
);
  import mgsfr_pkg::*;

  typedef enum logic [3:0] {
    PhStart = 4'b0001,
    PhFunc  = 4'b0010,
    PhCount = 4'b0100,
    PhBody  = 4'b1000
  } phase_e;

  // Positions of the frame bytes that the decode needs.
  localparam logic [CntW-1:0] PosPatHi = CntW'(5);
  localparam logic [CntW-1:0] PosPatLo = CntW'(6);
  localparam logic [CntW-1:0] Pos13    = CntW'(13);
  localparam logic [CntW-1:0] Pos14    = CntW'(14);
  localparam logic [CntW-1:0] Pos15    = CntW'(15);
  localparam logic [CntW-1:0] Pos16    = CntW'(16);
  localparam logic [CntW-1:0] Pos17    = CntW'(17);
  localparam logic [CntW-1:0] Pos18    = CntW'(18);
  localparam logic [CntW-1:0] Pos19    = CntW'(19);
  localparam logic [CntW-1:0] LastPos  = CntW'(FrameLen - 1);
  localparam logic [CntW-1:0] CrcEnd   = CntW'(FrameLen - 2);
  localparam logic [CntW-1:0] EndCnt   = CntW'(FrameLen);

  // Strip pattern codes.
  localparam logic [15:0] PatNone   = 16'd0;
  localparam logic [15:0] PatOneA   = 16'd1;
  localparam logic [15:0] PatOneB   = 16'd2;
  localparam logic [15:0] PatTwoA   = 16'd3;
  localparam logic [15:0] PatOneC   = 16'd4;
  localparam logic [15:0] PatTwoB   = 16'd6;
  localparam logic [15:0] PatThree  = 16'd7;

  // One byte through the reflected CRC-16.
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  phase_e      phase_q, phase_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] idle_q, idle_d;
  logic [15:0] idle_limit_q;

  // Frame bytes kept for the decode.
  logic [7:0] addr_q, pat_hi_q, pat_lo_q;
  logic [7:0] b13_q, b14_q, b15_q, b16_q, b17_q, b18_q, b19_q;

  out_item_t out_q, skid_q, res;
  logic      out_valid_q, skid_valid_q;

  logic            in_fire, emit, pop;
  logic [CntW-1:0] idx;
  logic [15:0]     idle_inc;

  assign in_fire = in_valid_i & in_ready_o;
  assign in_ready_o = ~skid_valid_q;
  assign pop = out_valid_q & out_ready_i;
  assign idx = (cnt_q >= EndCnt) ? LastPos : cnt_q;
  assign idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;

  // Parser state update for one beat.
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    idle_d  = idle_q;
    emit    = 1'b0;
    if (in_fire) begin
      if (in_data_i.func) begin
        idle_d = idle_inc;
        if (idle_inc >= idle_limit_q) begin
          idle_d  = '0;
          phase_d = PhStart;
          cnt_d   = '0;
        end
      end else begin
        idle_d = '0;
        unique case (phase_q)
          PhStart: begin
            if (in_data_i.data_byte <= MaxAddr) begin
              crc_d   = crc_feed(CrcInit, in_data_i.data_byte);
              cnt_d   = CntW'(1);
              phase_d = PhFunc;
            end
          end
          PhFunc: begin
            if (in_data_i.data_byte == FuncRead) begin
              crc_d   = crc_feed(crc_q, in_data_i.data_byte);
              cnt_d   = CntW'(2);
              phase_d = PhCount;
            end else begin
              phase_d = PhStart;
            end
          end
          PhCount: begin
            if (in_data_i.data_byte == ByteCount) begin
              crc_d   = crc_feed(crc_q, in_data_i.data_byte);
              cnt_d   = CntW'(3);
              phase_d = PhBody;
            end else begin
              phase_d = PhStart;
            end
          end
          default: begin
            if (idx < CrcEnd) begin
              crc_d = crc_feed(crc_q, in_data_i.data_byte);
            end
            if (idx == LastPos) begin
              emit    = 1'b1;
              phase_d = PhStart;
              cnt_d   = '0;
            end else begin
              cnt_d = idx + CntW'(1);
            end
          end
        endcase
      end
    end
  end

  // Frame decode; the last byte is the one arriving now.
  always_comb begin
    logic [15:0] w13, w15, w17;
    logic        addr_ok, crc_ok, acc;
    w13     = {b13_q, b14_q};
    w15     = {b15_q, b16_q};
    w17     = {b17_q, b18_q};
    addr_ok = (addr_q >= 8'd1) && (addr_q <= MaxAddr);
    crc_ok  = (b19_q == crc_q[7:0]) && (in_data_i.data_byte == crc_q[15:8]);
    acc     = addr_ok & crc_ok;
    res = '0;
    res.sensor_index = addr_ok ? (addr_q[1:0] - 2'd1) : 2'd0;
    res.crc_ok       = crc_ok;
    res.address_ok   = addr_ok;
    res.accepted     = acc;
    res.pattern_word = {pat_hi_q, pat_lo_q};
    if (acc) begin
      unique case (res.pattern_word)
        PatNone: begin
          res.pattern_known = 1'b1;
        end
        PatOneA, PatOneB, PatOneC: begin
          res.pattern_known = 1'b1;
          res.strip_count   = 2'd1;
          res.left_ofs      = w15;
        end
        PatTwoA: begin
          res.pattern_known = 1'b1;
          res.strip_count   = 2'd2;
          res.left_ofs      = w15;
          res.mid_ofs       = w13;
        end
        PatTwoB: begin
          res.pattern_known = 1'b1;
          res.strip_count   = 2'd2;
          res.left_ofs      = w17;
          res.mid_ofs       = w15;
        end
        PatThree: begin
          res.pattern_known = 1'b1;
          res.strip_count   = 2'd3;
          res.left_ofs      = w17;
          res.mid_ofs       = w15;
          res.right_ofs     = w13;
        end
        default: begin
          res.pattern_known = 1'b0;
        end
      endcase
    end
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhStart;
      cnt_q        <= '0;
      crc_q        <= CrcInit;
      idle_q       <= '0;
      idle_limit_q <= IdleLimitRst;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      idle_q  <= idle_d;
      if (cfg_we_i) begin
        idle_limit_q <= cfg_wdata_i;
      end
    end
  end

  // Capture of the frame bytes at their fixed positions.
  always_ff @(posedge clk_i) begin
    if (in_fire && !in_data_i.func) begin
      if (phase_q == PhStart) begin
        addr_q <= in_data_i.data_byte;
      end
      if (phase_q == PhBody) begin
        if (idx == PosPatHi) pat_hi_q <= in_data_i.data_byte;
        if (idx == PosPatLo) pat_lo_q <= in_data_i.data_byte;
        if (idx == Pos13) b13_q <= in_data_i.data_byte;
        if (idx == Pos14) b14_q <= in_data_i.data_byte;
        if (idx == Pos15) b15_q <= in_data_i.data_byte;
        if (idx == Pos16) b16_q <= in_data_i.data_byte;
        if (idx == Pos17) b17_q <= in_data_i.data_byte;
        if (idx == Pos18) b18_q <= in_data_i.data_byte;
        if (idx == Pos19) b19_q <= in_data_i.data_byte;
      end
    end
  end

  // Result register with a skid stage behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !pop) begin
        if (emit) begin
          skid_valid_q <= 1'b1;
        end
      end else if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_valid_q && !pop) begin
      if (emit) begin
        skid_q <= res;
      end
    end else if (skid_valid_q) begin
      out_q <= skid_q;
    end else if (emit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: tb/modbus_guide_sensor_frame_receiver_core_test.sv
module modbus_guide_sensor_frame_receiver_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mgsfr_pkg::*;

  // Strip pattern words that the decoder knows; anything else is reserved.
  localparam logic [15:0] PatNone     = 16'd0;
  localparam logic [15:0] StripA      = 16'd1;
  localparam logic [15:0] StripB      = 16'd2;
  localparam logic [15:0] StripAB     = 16'd3;
  localparam logic [15:0] StripC      = 16'd4;
  localparam logic [15:0] PatReserved = 16'd5;
  localparam logic [15:0] StripBC     = 16'd6;
  localparam logic [15:0] StripABC    = 16'd7;

  localparam int unsigned CyclesMax = 1_500_000;

  // Tracks the hunt for response frames and holds the decoded frames that are still owed.
  class strip_frame_tracker;
    typedef enum logic [1:0] {HuntAddr, HuntFunc, HuntCount, InBody} hunt_e;

    logic [15:0] idle_limit;
    hunt_e       phase;
    int unsigned byte_idx;
    logic [7:0]  frame [FrameLen];
    logic [15:0] crc;
    logic [15:0] idle_run;
    out_item_t   pending[$];
    int unsigned errors;
    int unsigned frames_due;
    int unsigned frames_seen;
    int unsigned frames_accepted;
    int unsigned useful_beats;

    function new();
      idle_limit = IdleLimitRst;
      phase = HuntAddr;
      byte_idx = 0;
      crc = CrcInit;
      idle_run = '0;
      foreach (frame[i]) frame[i] = 8'h00;
      errors = 0;
      frames_due = 0;
      frames_seen = 0;
      frames_accepted = 0;
      useful_beats = 0;
    endfunction

    // Bytewise Modbus CRC-16, LSB first.
    static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic [15:0] r;
      r = c ^ {8'h00, b};
      for (int i = 0; i < 8; i++) r = r[0] ? ((r >> 1) ^ CrcPoly) : (r >> 1);
      return r;
    endfunction

    function logic [15:0] word_at(int unsigned hi);
      return {frame[hi], frame[hi + 1]};
    endfunction

    // Decode a completed frame into the result the block must produce.
    function out_item_t decode_frame();
      out_item_t o;
      o = '0;
      o.address_ok   = frame[0] >= 8'd1 && frame[0] <= MaxAddr;
      o.sensor_index = o.address_ok ? 2'(frame[0] - 8'd1) : 2'd0;
      o.crc_ok       = frame[FrameLen - 2] == crc[7:0] && frame[FrameLen - 1] == crc[15:8];
      o.accepted     = o.address_ok && o.crc_ok;
      o.pattern_word = word_at(5);
      if (o.accepted) begin
        o.pattern_known = 1'b1;
        case (o.pattern_word)
          PatNone: ;
          StripA, StripB, StripC: begin
            o.strip_count = 2'd1;
            o.left_ofs    = word_at(15);
          end
          StripAB: begin
            o.strip_count = 2'd2;
            o.left_ofs    = word_at(15);
            o.mid_ofs     = word_at(13);
          end
          StripBC: begin
            o.strip_count = 2'd2;
            o.left_ofs    = word_at(17);
            o.mid_ofs     = word_at(15);
          end
          StripABC: begin
            o.strip_count = 2'd3;
            o.left_ofs    = word_at(17);
            o.mid_ofs     = word_at(15);
            o.right_ofs   = word_at(13);
          end
          default: o.pattern_known = 1'b0;
        endcase
      end
      return o;
    endfunction

    // Advance the hunt by one accepted input beat.
    function void note_beat(in_item_t beat);
      useful_beats++;
      if (beat.func) begin
        if (idle_run != 16'hFFFF) idle_run++;
        if (idle_run >= idle_limit) begin
          idle_run = '0;
          phase = HuntAddr;
          byte_idx = 0;
        end
        return;
      end
      idle_run = '0;
      case (phase)
        HuntAddr: begin
          if (beat.data_byte <= MaxAddr) begin
            frame[0] = beat.data_byte;
            crc = crc_step(CrcInit, beat.data_byte);
            byte_idx = 1;
            phase = HuntFunc;
          end else begin
            // Bytes above the address range are simply dropped.
            useful_beats--;
          end
        end
        HuntFunc: begin
          if (beat.data_byte == FuncRead) begin
            frame[1] = beat.data_byte;
            crc = crc_step(crc, beat.data_byte);
            byte_idx = 2;
            phase = HuntCount;
          end else begin
            phase = HuntAddr;
          end
        end
        HuntCount: begin
          if (beat.data_byte == ByteCount) begin
            frame[2] = beat.data_byte;
            crc = crc_step(crc, beat.data_byte);
            byte_idx = 3;
            phase = InBody;
          end else begin
            phase = HuntAddr;
          end
        end
        default: begin
          frame[byte_idx] = beat.data_byte;
          // The two trailing CRC bytes are not folded into the CRC.
          if (byte_idx < FrameLen - 2) crc = crc_step(crc, beat.data_byte);
          byte_idx++;
          if (byte_idx >= FrameLen) begin
            pending.push_back(decode_frame());
            frames_due++;
            phase = HuntAddr;
            byte_idx = 0;
          end
        end
      endcase
    endfunction

    function void compare(string field, logic [15:0] want_v, logic [15:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: frame %0d field %s expected %h got %h",
                 $time, frames_seen, field, want_v, got_v);
        errors++;
      end
    endfunction

    // Check one result beat against the oldest frame still owed.
    function void check_frame(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: result beat %h with no frame pending", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      frames_seen++;
      if (want.accepted) frames_accepted++;
      compare("sensor_index", want.sensor_index, got.sensor_index);
      compare("crc_ok", want.crc_ok, got.crc_ok);
      compare("address_ok", want.address_ok, got.address_ok);
      compare("accepted", want.accepted, got.accepted);
      compare("pattern_word", want.pattern_word, got.pattern_word);
      compare("pattern_known", want.pattern_known, got.pattern_known);
      compare("strip_count", want.strip_count, got.strip_count);
      compare("left_ofs", want.left_ofs, got.left_ofs);
      compare("mid_ofs", want.mid_ofs, got.mid_ofs);
      compare("right_ofs", want.right_ofs, got.right_ofs);
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_we_i    = 1'b0;
  logic [15:0] cfg_wdata_i = '0;

  strip_frame_tracker tracker = new();

  bit          calm        = 1'b0;
  int unsigned stall_left  = 0;
  int unsigned cycle_count = 0;
  int unsigned beats_sent  = 0;
  logic [15:0] mid_limit;

  modbus_guide_sensor_frame_receiver_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CyclesMax) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result side: check each accepted beat, then pick ready for the next cycle.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) tracker.check_frame(out_data_o);
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3) : $urandom_range(10, 40);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Gaps are mostly absent or short, with an occasional long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] random_addr();
    return ($urandom_range(0, 9) < 8) ? 8'($urandom_range(1, 4)) : 8'h00;
  endfunction

  function automatic logic [15:0] random_pattern();
    return ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, 7)) : 16'($urandom);
  endfunction

  function automatic logic [7:0] other_than(logic [7:0] v);
    logic [7:0] b;
    do b = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 4)) : 8'($urandom);
    while (b == v);
    return b;
  endfunction

  // Drive one input beat and hold it until the block takes it.
  task automatic send_beat(bit is_tick, logic [7:0] b);
    in_item_t    beat;
    int unsigned gap;
    beat.func      = is_tick;
    beat.data_byte = b;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_beat(beat);
    beats_sent++;
  endtask

  task automatic idle_ticks(int unsigned n);
    repeat (n) send_beat(1'b1, 8'($urandom));
  endtask

  // Build a response frame and send its first cut_at bytes, with an idle run before idle_pos.
  // A negative fill gives random body bytes.
  task automatic send_frame(logic [7:0] addr, logic [15:0] pattern, bit crc_bad, int fill,
                            int unsigned cut_at, int unsigned idle_pos, int unsigned idle_len);
    logic [7:0]  f [FrameLen];
    logic [15:0] c;
    c = CrcInit;
    for (int i = 0; i < FrameLen; i++) f[i] = (fill < 0) ? 8'($urandom) : 8'(fill);
    f[0] = addr;
    f[1] = FuncRead;
    f[2] = ByteCount;
    f[5] = pattern[15:8];
    f[6] = pattern[7:0];
    for (int i = 0; i < FrameLen - 2; i++) c = strip_frame_tracker::crc_step(c, f[i]);
    f[FrameLen - 2] = c[7:0];
    f[FrameLen - 1] = c[15:8];
    if (crc_bad) f[FrameLen - 2 + $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
    for (int i = 0; i < cut_at; i++) begin
      if (i == idle_pos) idle_ticks(idle_len);
      send_beat(1'b0, f[i]);
    end
  endtask

  task automatic good_frame(logic [7:0] addr, logic [15:0] pattern);
    send_frame(addr, pattern, 1'b0, -1, FrameLen, FrameLen, 0);
  endtask

  // Hold the input side until every owed frame has come out.
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending.size() != 0);
  endtask

  task automatic write_idle_limit(logic [15:0] v);
    settle();
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.idle_limit = v;
  endtask

  // One random sequence: mostly whole frames, the rest noise, idle runs and broken starts.
  task automatic random_sequence();
    int unsigned r;
    int unsigned lim;
    int unsigned n;
    r   = $urandom_range(0, 99);
    lim = tracker.idle_limit;
    if (r < 65) begin
      n = 0;
      if (lim > 1 && $urandom_range(0, 3) == 0)
        n = $urandom_range(1, (lim - 1 < 8) ? lim - 1 : 8);
      send_frame(random_addr(), random_pattern(), $urandom_range(0, 99) < 15, -1, FrameLen,
                 $urandom_range(1, FrameLen - 1), n);
    end else if (r < 75) begin
      // Truncated frame, normally followed by enough idle ticks to drop it.
      send_frame(random_addr(), random_pattern(), 1'b0, -1, $urandom_range(1, FrameLen - 1),
                 FrameLen, 0);
      idle_ticks((lim == 0) ? 1 : (lim <= 200) ? lim : $urandom_range(1, 50));
    end else if (r < 85) begin
      repeat ($urandom_range(1, 6)) send_beat(1'b0, 8'($urandom));
    end else if (r < 92) begin
      idle_ticks($urandom_range(1, (lim < 100) ? lim + 2 : 100));
    end else begin
      // Start byte followed by a wrong function or a wrong byte count.
      send_beat(1'b0, 8'($urandom_range(0, MaxAddr)));
      if ($urandom_range(0, 1) != 0) begin
        send_beat(1'b0, other_than(FuncRead));
      end else begin
        send_beat(1'b0, FuncRead);
        send_beat(1'b0, other_than(ByteCount));
      end
    end
  endtask

  task automatic run_segment(int unsigned beats, int unsigned frames);
    int unsigned b0;
    int unsigned f0;
    b0 = tracker.useful_beats;
    f0 = tracker.frames_due;
    while (tracker.useful_beats - b0 < beats || tracker.frames_due - f0 < frames) begin
      if ($urandom_range(0, 9) == 0) calm = ~calm;
      random_sequence();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Every pattern once, all-zero and all-one bodies at the ends.
    for (int p = 0; p < 8; p++)
      send_frame(8'((p % 4) + 1), 16'(p), 1'b0, (p == 7) ? 255 : (p == 0) ? 0 : -1,
                 FrameLen, FrameLen, 0);
    good_frame(8'd4, 16'hFFFF);
    good_frame(8'd0, StripABC);
    send_frame(8'd3, StripAB, 1'b1, -1, FrameLen, FrameLen, 0);
    good_frame(8'd1, PatReserved);

    // A wrong function byte is not taken as a new start byte.
    send_beat(1'b0, 8'h02);
    send_beat(1'b0, 8'h01);
    send_beat(1'b0, FuncRead);
    send_beat(1'b0, ByteCount);
    good_frame(8'd2, StripBC);

    // A wrong byte count restarts the hunt.
    send_beat(1'b0, 8'h01);
    send_beat(1'b0, FuncRead);
    send_beat(1'b0, 8'h00);
    good_frame(8'd3, StripC);

    // One idle tick short of the limit keeps the frame; the full limit drops it.
    send_frame(8'd4, StripABC, 1'b0, -1, FrameLen, 10, IdleLimitRst - 1);
    send_frame(8'd1, StripA, 1'b0, -1, FrameLen, 10, IdleLimitRst);
    good_frame(8'd2, StripB);

    write_idle_limit(16'd1);
    run_segment(60, 4);

    write_idle_limit(16'd0);
    run_segment(40, 3);

    // Longest limit: an idle run well past the reset limit keeps the frame.
    write_idle_limit(16'hFFFF);
    send_frame(8'd2, StripAB, 1'b0, -1, FrameLen, 12, 150);
    settle();
    run_segment(60, 4);

    mid_limit = 16'($urandom_range(2, 30));
    write_idle_limit(mid_limit);
    run_segment(60, 4);

    write_idle_limit(IdleLimitRst);
    run_segment(60, 4);

    settle();
    repeat (5) @(posedge clk_i);
    $display("Run: %0d input beats, %0d frames checked, %0d of them accepted.",
             beats_sent, tracker.frames_seen, tracker.frames_accepted);
    $display("Idle limits used: 100, 1, 0, 65535 and %0d, with random gaps and stalls.",
             mid_limit);
    if (tracker.errors == 0 && tracker.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
